[rtl/okd_pkg.sv]
// ----------------------------------------------------------------------------
// okd_pkg
// shared types, codes and helpers for the ordered key decoder
// ----------------------------------------------------------------------------
package okd_pkg;

    localparam int unsigned MAX_FIELDS  = 8;
    localparam int unsigned FCNT_W      = 4;
    localparam int unsigned FIDX_W      = 3;
    localparam int unsigned RQ_DEPTH    = 8;
    localparam int unsigned RQ_PTR_W    = $clog2(RQ_DEPTH);
    localparam int unsigned RQ_CNT_W    = RQ_PTR_W + 1;
    localparam int unsigned OUT_DATA_W  = 80;
    localparam int unsigned OUT_USED_W  = 78;
    localparam logic [FCNT_W-1:0] MAX_FIELDS_C = FCNT_W'(MAX_FIELDS);
    localparam logic [63:0] SIGN_FLIP = 64'h8000_0000_0000_0000;

    localparam logic [7:0] BYTE_TERM    = 8'h00;
    localparam logic [7:0] BYTE_ESC     = 8'h01;
    localparam logic [7:0] BYTE_ESC_ONE = 8'h02;

    typedef enum logic [1:0] {
        KIND_INT    = 2'd0,
        KIND_BYTE   = 2'd1,
        KIND_END    = 2'd2,
        KIND_STATUS = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_TRUNC_INT    = 3'd1,
        ST_BAD_ESCAPE   = 3'd2,
        ST_UNTERMINATED = 3'd3,
        ST_TRAILING     = 3'd4
    } t_status;

    typedef enum logic {
        REG_FIELD_COUNT = 1'b0,
        REG_FIELD_TYPES = 1'b1
    } t_reg_idx;

    typedef struct packed {
        t_kind              kind;
        logic [FIDX_W-1:0]  field_index;
        logic [63:0]        int_value;
        logic [7:0]         string_byte;
        t_status            status;
        logic               last_result;
    } t_result;

    typedef struct packed {
        logic [FCNT_W-1:0]  field_count;
        logic [7:0]         field_types;
    } t_cfg;

    function automatic logic is_string_field(input logic [FCNT_W-1:0] idx,
                                             input logic [7:0] types);
        logic res;
        res = 1'b0;
        if (idx < FCNT_W'(8)) begin
            res = types[idx[FIDX_W-1:0]];
        end
        return res;
    endfunction

endpackage

[rtl/okd_cfg.sv]
// ----------------------------------------------------------------------------
// okd_cfg
// register file for the key schema, written and read over the apb port
// ----------------------------------------------------------------------------
module okd_cfg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready,
    output okd_pkg::t_cfg  o_cfg
);
    import okd_pkg::*;

    logic [FCNT_W-1:0] r_field_count;
    logic [7:0]        r_field_types;
    t_reg_idx          reg_idx;
    logic              wr_en;

    assign reg_idx = t_reg_idx'(paddr[2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field_count <= FCNT_W'(1);
            r_field_types <= 8'h00;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_FIELD_COUNT: r_field_count <= pwdata[FCNT_W-1:0];
                REG_FIELD_TYPES: r_field_types <= pwdata[7:0];
                default:         r_field_count <= r_field_count;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_FIELD_COUNT: prdata = {{(32-FCNT_W){1'b0}}, r_field_count};
            REG_FIELD_TYPES: prdata = {24'h0, r_field_types};
            default:         prdata = 32'h0;
        endcase
    end

    assign o_cfg.field_count = r_field_count;
    assign o_cfg.field_types = r_field_types;

endmodule

[rtl/okd_decode.sv]
// ----------------------------------------------------------------------------
// okd_decode
// input register and per-byte key decode, giving up to two results a byte
// ----------------------------------------------------------------------------
module okd_decode (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  okd_pkg::t_cfg   i_cfg,
    input  logic            i_in_valid,
    input  logic [7:0]      i_key_byte,
    input  logic            i_key_end,
    output logic            o_busy,
    output logic [1:0]      o_push_n,
    output okd_pkg::t_result o_res0,
    output okd_pkg::t_result o_res1
);
    import okd_pkg::*;

    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              r_in_end;

    logic [FCNT_W-1:0] r_fp,   n_fp;
    logic [2:0]        r_bp,   n_bp;
    logic [55:0]       r_part, n_part;
    logic              r_esc,  n_esc;
    t_status           r_err,  n_err;

    logic [FCNT_W-1:0] count;
    logic              cur_str;
    logic              d_valid;
    t_result           d_res;
    t_result           s_res;
    t_status           st;

    assign count   = (i_cfg.field_count > MAX_FIELDS_C) ? MAX_FIELDS_C : i_cfg.field_count;
    assign cur_str = is_string_field(r_fp, i_cfg.field_types);

    always_comb begin
        n_fp    = r_fp;
        n_bp    = r_bp;
        n_part  = r_part;
        n_esc   = r_esc;
        n_err   = r_err;
        d_valid = 1'b0;
        d_res   = '0;
        s_res   = '0;
        st      = ST_OK;
        d_res.field_index = r_fp[FIDX_W-1:0];
        if (r_in_valid && (r_err == ST_OK)) begin
            if (r_fp >= count) begin
                n_err = ST_TRAILING;
            end else if (!cur_str) begin
                if (r_bp != 3'd7) begin
                    n_part = {r_part[47:0], r_in_byte};
                    n_bp   = r_bp + 3'd1;
                end else begin
                    d_valid         = 1'b1;
                    d_res.kind      = KIND_INT;
                    d_res.int_value = {r_part, r_in_byte} ^ SIGN_FLIP;
                    n_fp            = r_fp + FCNT_W'(1);
                    n_bp            = 3'd0;
                    n_part          = '0;
                end
            end else if (r_esc) begin
                if ((r_in_byte == BYTE_ESC) || (r_in_byte == BYTE_ESC_ONE)) begin
                    d_valid           = 1'b1;
                    d_res.kind        = KIND_BYTE;
                    d_res.string_byte = r_in_byte - 8'd1;
                    n_esc             = 1'b0;
                end else begin
                    n_err = ST_BAD_ESCAPE;
                end
            end else if (r_in_byte == BYTE_TERM) begin
                d_valid    = 1'b1;
                d_res.kind = KIND_END;
                n_fp       = r_fp + FCNT_W'(1);
            end else if (r_in_byte == BYTE_ESC) begin
                n_esc = 1'b1;
            end else begin
                d_valid           = 1'b1;
                d_res.kind        = KIND_BYTE;
                d_res.string_byte = r_in_byte;
            end
        end
        st = n_err;
        if ((st == ST_OK) && (n_fp < count)) begin
            st = is_string_field(n_fp, i_cfg.field_types) ? ST_UNTERMINATED : ST_TRUNC_INT;
        end
        s_res.kind        = KIND_STATUS;
        s_res.status      = st;
        s_res.last_result = 1'b1;
        if (r_in_valid && r_in_end) begin
            n_fp   = '0;
            n_bp   = '0;
            n_part = '0;
            n_esc  = 1'b0;
            n_err  = ST_OK;
        end
    end

    always_comb begin
        o_res0   = d_valid ? d_res : s_res;
        o_res1   = s_res;
        o_push_n = 2'({1'b0, r_in_valid && d_valid} + {1'b0, r_in_valid && r_in_end});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_fp       <= '0;
            r_bp       <= '0;
            r_part     <= '0;
            r_esc      <= 1'b0;
            r_err      <= ST_OK;
        end else begin
            r_in_valid <= i_in_valid;
            r_fp       <= n_fp;
            r_bp       <= n_bp;
            r_part     <= n_part;
            r_esc      <= n_esc;
            r_err      <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid) begin
            r_in_byte <= i_key_byte;
            r_in_end  <= i_key_end;
        end
    end

    assign o_busy = r_in_valid;

endmodule

[rtl/okd_res_queue.sv]
// ----------------------------------------------------------------------------
// okd_res_queue
// result queue taking up to two results a cycle and giving one per transaction
// ----------------------------------------------------------------------------
module okd_res_queue (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [1:0]                i_push_n,
    input  okd_pkg::t_result          i_res0,
    input  okd_pkg::t_result          i_res1,
    input  logic                      i_pop,
    output logic                      o_valid,
    output okd_pkg::t_result          o_res,
    output logic [okd_pkg::RQ_CNT_W-1:0] o_count
);
    import okd_pkg::*;

    t_result               r_mem [RQ_DEPTH];
    logic [RQ_PTR_W-1:0]   r_wr_ptr;
    logic [RQ_PTR_W-1:0]   r_rd_ptr;
    logic [RQ_CNT_W-1:0]   r_count;
    logic [RQ_PTR_W-1:0]   wr_ptr1;
    logic                  pop_ok;

    assign wr_ptr1 = r_wr_ptr + RQ_PTR_W'(1);
    assign pop_ok  = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (i_push_n != 2'd0) begin
            r_mem[r_wr_ptr] <= i_res0;
        end
        if (i_push_n == 2'd2) begin
            r_mem[wr_ptr1] <= i_res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + RQ_PTR_W'(i_push_n);
            r_rd_ptr <= r_rd_ptr + RQ_PTR_W'(pop_ok);
            r_count  <= r_count + RQ_CNT_W'(i_push_n) - RQ_CNT_W'(pop_ok);
        end
    end

    assign o_valid = (r_count != '0);
    assign o_res   = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

[rtl/ordered_key_decoder_core.sv]
// ----------------------------------------------------------------------------
// ordered_key_decoder_core
// streaming decoder for order-preserving database keys
// ----------------------------------------------------------------------------
// One key byte is taken per cycle while s_axis_tready is high. A byte is
// registered, decoded the next cycle against the schema (up to eight int64
// or escaped string fields) and its results, none, one or two, land in an
// eight-entry result queue. Input is taken while the queue has room for
// everything in flight; with a consumer that is always ready the block
// sustains one byte per cycle while bytes average at most one result each;
// a key's final byte that gives a data result also queues a status result.
// Results for a key that ends with a non-ok status are to be discarded.
module ordered_key_decoder_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // key_byte
    input  logic         s_axis_tlast,   // key_end
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [79:0]  m_axis_tdata,   // field_index, int_value, string_byte, status, zero pad
    output logic [1:0]   m_axis_tuser,   // kind
    output logic         m_axis_tlast,   // last_result
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import okd_pkg::*;

    t_cfg                cfg;
    logic                in_acc;
    logic                busy;
    logic [1:0]          push_n;
    t_result             res0;
    t_result             res1;
    t_result             out_res;
    logic [RQ_CNT_W-1:0] q_count;
    logic [RQ_CNT_W:0]   reserved;

    okd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign reserved      = {1'b0, q_count} + {{(RQ_CNT_W-1){1'b0}}, busy, 1'b0};
    assign s_axis_tready = (reserved <= (RQ_CNT_W+1)'(RQ_DEPTH - 2));
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    okd_decode u_decode (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_in_valid (in_acc),
        .i_key_byte (s_axis_tdata),
        .i_key_end  (s_axis_tlast),
        .o_busy     (busy),
        .o_push_n   (push_n),
        .o_res0     (res0),
        .o_res1     (res1)
    );

    okd_res_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n (push_n),
        .i_res0   (res0),
        .i_res1   (res1),
        .i_pop    (m_axis_tready),
        .o_valid  (m_axis_tvalid),
        .o_res    (out_res),
        .o_count  (q_count)
    );

    assign m_axis_tuser = out_res.kind;
    assign m_axis_tlast = out_res.last_result;
    assign m_axis_tdata = {{(OUT_DATA_W-OUT_USED_W){1'b0}}, out_res.status,
                           out_res.string_byte, out_res.int_value, out_res.field_index};

endmodule

[rtl/okd_checker.sv]
// ----------------------------------------------------------------------------
// okd_checker
// port-level checks on the ordered key decoder, bound to the top level
// ----------------------------------------------------------------------------
module okd_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [79:0]  m_axis_tdata,
    input logic [1:0]   m_axis_tuser,
    input logic         m_axis_tlast
);
    import okd_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid straight after reset");

    a_last_is_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == KIND_STATUS)))
        else $error("tlast not matched to status result");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == KIND_STATUS) |->
            (m_axis_tdata[77:75] <= ST_TRAILING) && (m_axis_tdata[74:0] == '0))
        else $error("malformed status result");

    a_data_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != KIND_STATUS) |->
            (m_axis_tdata[77:75] == ST_OK) && (m_axis_tdata[79:78] == 2'b00))
        else $error("status bits set on a data result");

endmodule

bind ordered_key_decoder_core okd_checker u_okd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
